// ===== hdl/ahsg_pkg.sv =====
package ahsg_pkg;

    // Input vector format.
    localparam int VecW = 16;
    localparam int FracBits = 8;
    localparam int PosShift = 16 - FracBits;

    // Configuration register indexes.
    localparam logic [1:0] RegHorizCenter = 2'd0;
    localparam logic [1:0] RegVertCenter  = 2'd1;
    localparam logic [1:0] RegHorizScale  = 2'd2;
    localparam logic [1:0] RegVertScale   = 2'd3;
    localparam int CfgIdxW = 8;

    // Head half-width constant, 0.5*sqrt(1/2) in Q.16.
    localparam logic [14:0] HeadK = 15'd23170;

    // Normalised squared length is 62 bits, its root 31 bits.
    localparam int LenW = 62;
    localparam int RootW = 31;
    localparam int ShW = 5;

    // Numerator 2*|a|*2^k*K fits in 64 bits; quotient below 2^17.
    localparam int NumW = 64;
    localparam int DenW = 32;
    localparam int QW = 17;

    typedef struct packed {
        logic signed [VecW-1:0] x;
        logic signed [VecW-1:0] y;
        logic                   degen;
        logic [ShW-1:0]         k;
        logic [LenW-1:0]        len;
    } ahsg_item_t;

    typedef struct packed {
        logic [11:0] hc;
        logic [11:0] vc;
        logic [9:0]  hs;
        logic [9:0]  vs;
    } ahsg_cfg_t;

    // Round to nearest pixel (halves up) and saturate to 16 bits.
    function automatic logic signed [15:0] to_pixel(input logic signed [47:0] v);
        logic signed [47:0] t;
        logic signed [31:0] q;
        begin
            t = v + 48'sd32768;
            q = t[47:16];
            if (q > 32'sd32767)
                to_pixel = 16'sh7fff;
            else if (q < -32'sd32768)
                to_pixel = 16'sh8000;
            else
                to_pixel = q[15:0];
        end
    endfunction

endpackage

// ===== hdl/ahsg_front.sv =====
// Front end: squared length, degenerate test and normalising shift count.
module ahsg_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [ahsg_pkg::VecW-1:0] in_x,
    input  logic signed [ahsg_pkg::VecW-1:0] in_y,
    output logic                       out_valid,
    output ahsg_pkg::ahsg_item_t       out_item
);

    logic                 s1_valid_reg;
    logic signed [ahsg_pkg::VecW-1:0] s1_x_reg, s1_y_reg;
    logic [31:0]          s1_sq_reg;
    logic [31:0]          sq_next;
    logic [15:0]          ax, ay;
    logic                 out_valid_reg;
    ahsg_pkg::ahsg_item_t item_reg, item_next;
    logic [ahsg_pkg::LenW-1:0] len_n;
    logic [ahsg_pkg::ShW-1:0]  lz;

    // Squared magnitude, one multiplier per component.
    assign ax = in_x[15] ? 16'(-in_x) : 16'(in_x);
    assign ay = in_y[15] ? 16'(-in_y) : 16'(in_y);
    assign sq_next = 32'(ax * ax) + 32'(ay * ay);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg  <= in_x;
        s1_y_reg  <= in_y;
        s1_sq_reg <= sq_next;
        item_reg  <= item_next;
    end

    // Shift count: the length is brought to at least 2^60 in steps of four.
    always_comb
    begin
        lz = '0;
        for (int i = 15; i >= 0; i--)
        begin
            if (s1_sq_reg[2*i+1 -: 2] != 2'b00 && lz == '0)
                lz = ahsg_pkg::ShW'(15 - i);
        end
        if (s1_sq_reg[31:30] != 2'b00)
            lz = '0;
        len_n = {30'd0, s1_sq_reg} << (2 * ({1'b0, lz} + 6'd15));
        item_next.x     = s1_x_reg;
        item_next.y     = s1_y_reg;
        item_next.degen = (s1_sq_reg == '0);
        item_next.k     = ahsg_pkg::ShW'({1'b0, lz} + 6'd15);
        item_next.len   = len_n;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hdl/ahsg_queue.sv =====
// Short register queue between front and back ends.
module ahsg_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ahsg_pkg::ahsg_item_t in_item,
    output logic                 out_valid,
    output ahsg_pkg::ahsg_item_t out_item
);

    logic                 valid_reg;
    ahsg_pkg::ahsg_item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            item_reg <= in_item;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== hdl/ahsg_back.sv =====
// Back end: pipelined square root, two pipelined divisions, screen mapping.
module ahsg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ahsg_pkg::ahsg_item_t in_item,
    input  ahsg_pkg::ahsg_cfg_t  cfg,
    output logic                 res_valid,
    output logic signed [15:0]   tip_col,
    output logic signed [15:0]   tip_row,
    output logic signed [15:0]   left_col,
    output logic signed [15:0]   left_row,
    output logic signed [15:0]   right_col,
    output logic signed [15:0]   right_row,
    output logic                 degenerate
);

    localparam int RS = ahsg_pkg::RootW;
    localparam int QS = ahsg_pkg::QW;

    // Square root: one result bit per stage.
    logic [RS:0]                   sv_reg;
    ahsg_pkg::ahsg_item_t          si_reg [RS+1];
    logic [ahsg_pkg::LenW+1:0]     srem_reg [RS+1];
    logic [RS-1:0]                 sroot_reg [RS+1];

    always_comb
    begin
        si_reg[0]    = in_item;
        srem_reg[0]  = {2'b00, in_item.len};
        sroot_reg[0] = '0;
    end

    assign sv_reg[0] = in_valid;

    for (genvar s = 0; s < RS; s++)
    begin : g_sqrt
        logic [ahsg_pkg::LenW+1:0] trial;
        logic [ahsg_pkg::LenW+1:0] bitv;
        assign bitv  = (ahsg_pkg::LenW+2)'(1) << (2 * (RS - 1 - s));
        assign trial = ((ahsg_pkg::LenW+2)'(sroot_reg[s]) << (RS - s)) + bitv;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[s+1] <= 1'b0;
            else
                sv_reg[s+1] <= sv_reg[s];
        end
        always_ff @(posedge clk)
        begin
            si_reg[s+1] <= si_reg[s];
            if (srem_reg[s] >= trial)
            begin
                srem_reg[s+1]  <= srem_reg[s] - trial;
                sroot_reg[s+1] <= sroot_reg[s] | (RS'(1) << (RS - 1 - s));
            end
            else
            begin
                srem_reg[s+1]  <= srem_reg[s];
                sroot_reg[s+1] <= sroot_reg[s];
            end
        end
    end

    // Numerators 2*|a|*2^k*K + r, built in two registered steps.
    ahsg_pkg::ahsg_item_t      n_item_reg, m_item_reg;
    logic                      n_valid_reg, m_valid_reg;
    logic [RS-1:0]             n_r_reg, m_r_reg;
    logic [16:0]               n_aa_reg, n_ab_reg;
    logic                      n_sa_reg, n_sb_reg;
    logic [31:0]               m_pa_reg, m_pb_reg;
    logic                      m_sa_reg, m_sb_reg;
    logic signed [16:0]        dxy, sxy;

    assign dxy = 17'(si_reg[RS].x) - 17'(si_reg[RS].y);
    assign sxy = 17'(si_reg[RS].x) + 17'(si_reg[RS].y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            n_valid_reg <= sv_reg[RS];
            m_valid_reg <= n_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_item_reg <= si_reg[RS];
        n_r_reg    <= sroot_reg[RS];
        n_sa_reg   <= dxy[16];
        n_sb_reg   <= sxy[16];
        n_aa_reg   <= dxy[16] ? 17'(-dxy) : 17'(dxy);
        n_ab_reg   <= sxy[16] ? 17'(-sxy) : 17'(sxy);
        m_item_reg <= n_item_reg;
        m_r_reg    <= n_r_reg;
        m_sa_reg   <= n_sa_reg;
        m_sb_reg   <= n_sb_reg;
        m_pa_reg   <= 32'(n_aa_reg * ahsg_pkg::HeadK);
        m_pb_reg   <= 32'(n_ab_reg * ahsg_pkg::HeadK);
    end

    // Restoring division, one quotient bit per stage. Quotient below 2^17.
    logic [QS:0]               dv_reg;
    ahsg_pkg::ahsg_item_t      di_reg [QS+1];
    logic [RS-1:0]             dr_reg [QS+1];
    logic [ahsg_pkg::NumW-1:0] dna_reg [QS+1];
    logic [ahsg_pkg::NumW-1:0] dnb_reg [QS+1];
    logic [QS-1:0]             dqa_reg [QS+1];
    logic [QS-1:0]             dqb_reg [QS+1];
    logic                      dsa_reg [QS+1];
    logic                      dsb_reg [QS+1];

    always_comb
    begin
        di_reg[0]  = m_item_reg;
        dr_reg[0]  = m_r_reg;
        dna_reg[0] = ((ahsg_pkg::NumW'(m_pa_reg) << m_item_reg.k) << 1)
                     + ahsg_pkg::NumW'(m_r_reg);
        dnb_reg[0] = ((ahsg_pkg::NumW'(m_pb_reg) << m_item_reg.k) << 1)
                     + ahsg_pkg::NumW'(m_r_reg);
        dqa_reg[0] = '0;
        dqb_reg[0] = '0;
        dsa_reg[0] = m_sa_reg;
        dsb_reg[0] = m_sb_reg;
    end

    assign dv_reg[0] = m_valid_reg;

    for (genvar s = 0; s < QS; s++)
    begin : g_div
        localparam int Sh = QS - s;
        logic [ahsg_pkg::NumW+QS:0] dsh;
        logic                       ga, gb;
        assign dsh = {{(QS+1){1'b0}}, dr_reg[s], 1'b0} << (Sh - 1);
        assign ga  = {{(QS+1){1'b0}}, dna_reg[s]} >= dsh;
        assign gb  = {{(QS+1){1'b0}}, dnb_reg[s]} >= dsh;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[s+1] <= 1'b0;
            else
                dv_reg[s+1] <= dv_reg[s];
        end
        always_ff @(posedge clk)
        begin
            di_reg[s+1]  <= di_reg[s];
            dr_reg[s+1]  <= dr_reg[s];
            dsa_reg[s+1] <= dsa_reg[s];
            dsb_reg[s+1] <= dsb_reg[s];
            dna_reg[s+1] <= ga ? dna_reg[s] - dsh[ahsg_pkg::NumW-1:0] : dna_reg[s];
            dnb_reg[s+1] <= gb ? dnb_reg[s] - dsh[ahsg_pkg::NumW-1:0] : dnb_reg[s];
            dqa_reg[s+1] <= dqa_reg[s] | (QS'(ga) << (Sh - 1));
            dqb_reg[s+1] <= dqb_reg[s] | (QS'(gb) << (Sh - 1));
        end
    end

    // Head points in Q.16, then one multiply per coordinate.
    logic signed [31:0] px, py, oa, ob, lx, ly, rx, ry;
    logic               e_valid_reg, f_valid_reg;
    logic signed [31:0] e_p_reg [6];
    logic               e_dg_reg, f_dg_reg;
    logic signed [47:0] f_v_reg [6];

    always_comb
    begin
        px = 32'(di_reg[QS].x) <<< ahsg_pkg::PosShift;
        py = 32'(di_reg[QS].y) <<< ahsg_pkg::PosShift;
        oa = dsa_reg[QS] ? -32'(dqa_reg[QS]) : 32'(dqa_reg[QS]);
        ob = dsb_reg[QS] ? -32'(dqb_reg[QS]) : 32'(dqb_reg[QS]);
        if (di_reg[QS].degen)
        begin
            lx = px; ly = py; rx = px; ry = py;
        end
        else
        begin
            lx = px - oa; ly = py - ob; rx = px - ob; ry = py + oa;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= dv_reg[QS];
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_p_reg[0] <= px; e_p_reg[1] <= py;
        e_p_reg[2] <= lx; e_p_reg[3] <= ly;
        e_p_reg[4] <= rx; e_p_reg[5] <= ry;
        e_dg_reg   <= di_reg[QS].degen;
        f_dg_reg   <= e_dg_reg;
        for (int i = 0; i < 6; i += 2)
        begin
            f_v_reg[i]   <= (48'(signed'({1'b0, cfg.hc})) <<< 16)
                            + 48'(e_p_reg[i]) * 48'(signed'({1'b0, cfg.hs}));
            f_v_reg[i+1] <= (48'(signed'({1'b0, cfg.vc})) <<< 16)
                            - 48'(e_p_reg[i+1]) * 48'(signed'({1'b0, cfg.vs}));
        end
    end

    // Output register: rounding and saturation.
    logic               o_valid_reg, o_dg_reg;
    logic signed [15:0] o_px_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else
            o_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        o_dg_reg <= f_dg_reg;
        for (int i = 0; i < 6; i++)
            o_px_reg[i] <= ahsg_pkg::to_pixel(f_v_reg[i]);
    end

    assign res_valid  = o_valid_reg;
    assign tip_col    = o_px_reg[0];
    assign tip_row    = o_px_reg[1];
    assign left_col   = o_px_reg[2];
    assign left_row   = o_px_reg[3];
    assign right_col  = o_px_reg[4];
    assign right_row  = o_px_reg[5];
    assign degenerate = o_dg_reg;

endmodule

// ===== hdl/arrow_head_screen_geometry_top.sv =====
// Arrow head screen geometry.
// Input channel: a transaction is taken at each rising edge with start high and
// busy low. busy is held low, so a vector may be presented every cycle.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Index 0 horizontal centre, 1 vertical centre,
// 2 horizontal scale, 3 vertical scale; other indexes are ignored.
// Write configuration only while no vector is in flight.
// Result: done pulses for one cycle with the tip, both head points and the
// degenerate flag. The receiver cannot stall the block.
// The pipeline stages are three in the front end and queue, 31 in the
// bit-per-stage square root, two building the numerators, 17 in the
// bit-per-stage divider and three for the mapping and the output;
// throughput is one vector per cycle.
// Reset clears every pipeline valid bit and loads centres 0 and scales 1.
module arrow_head_screen_geometry_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [15:0]   vec_x,
    input  logic signed [15:0]   vec_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ahsg_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 done,
    output logic signed [15:0]   tip_col,
    output logic signed [15:0]   tip_row,
    output logic signed [15:0]   left_col,
    output logic signed [15:0]   left_row,
    output logic signed [15:0]   right_col,
    output logic signed [15:0]   right_row,
    output logic                 degenerate
);

    ahsg_pkg::ahsg_cfg_t  cfg_reg;
    logic                 f_valid, q_valid;
    ahsg_pkg::ahsg_item_t f_item, q_item;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hc <= '0;
            cfg_reg.vc <= '0;
            cfg_reg.hs <= 10'd1;
            cfg_reg.vs <= 10'd1;
        end
        else if (cfg_valid && cfg_index[7:2] == '0)
        begin
            case (cfg_index[1:0])
                ahsg_pkg::RegHorizCenter: cfg_reg.hc <= cfg_data[11:0];
                ahsg_pkg::RegVertCenter:  cfg_reg.vc <= cfg_data[11:0];
                ahsg_pkg::RegHorizScale:  cfg_reg.hs <= cfg_data[9:0];
                ahsg_pkg::RegVertScale:   cfg_reg.vs <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    ahsg_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .in_x(vec_x), .in_y(vec_y), .out_valid(f_valid), .out_item(f_item)
    );

    ahsg_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_item(f_item),
        .out_valid(q_valid), .out_item(q_item)
    );

    ahsg_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_item(q_item),
        .cfg(cfg_reg), .res_valid(done),
        .tip_col(tip_col), .tip_row(tip_row),
        .left_col(left_col), .left_row(left_row),
        .right_col(right_col), .right_row(right_row),
        .degenerate(degenerate)
    );

endmodule

// ===== hdl/ahsg_checker.sv =====
// Port-level checks on the geometry block.
module ahsg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               cfg_ready,
    input logic               done,
    input logic               degenerate,
    input logic signed [15:0] tip_col,
    input logic signed [15:0] tip_row,
    input logic signed [15:0] left_col,
    input logic signed [15:0] left_row
);

    // The block never refuses a transaction.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready dropped");

    // A degenerate result has its left point on the tip.
    a_degen_col: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> left_col == tip_col)
        else $error("degenerate left column differs from tip");

    a_degen_row: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> left_row == tip_row)
        else $error("degenerate left row differs from tip");

endmodule

bind arrow_head_screen_geometry_top ahsg_checker u_ahsg_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy), .cfg_ready(cfg_ready),
    .done(done), .degenerate(degenerate), .tip_col(tip_col),
    .tip_row(tip_row), .left_col(left_col), .left_row(left_row)
);

// ===== tb/tb_arrow_head_screen_geometry_top.sv =====
module tb_arrow_head_screen_geometry_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 64;
    localparam int IdxW = ahsg_pkg::CfgIdxW;
    localparam logic [IdxW-1:0] RegFirstUnused = IdxW'(4);
    localparam logic [63:0] HeadHalfWidth = 64'd23170;

    typedef struct {
        logic signed [15:0] tip_col;
        logic signed [15:0] tip_row;
        logic signed [15:0] left_col;
        logic signed [15:0] left_row;
        logic signed [15:0] right_col;
        logic signed [15:0] right_row;
        logic               degenerate;
    } arrow_pixels_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] vec_x = '0;
    logic signed [15:0] vec_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IdxW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic done;
    logic signed [15:0] tip_col, tip_row, left_col, left_row, right_col, right_row;
    logic degenerate;

    // Shadow copy of the screen mapping registers.
    logic [11:0] sh_hc = 12'd0;
    logic [11:0] sh_vc = 12'd0;
    logic [9:0]  sh_hs = 10'd1;
    logic [9:0]  sh_vs = 10'd1;

    arrow_pixels_t pending_arrows[$];
    int errors = 0;
    int cycles = 0;
    int vectors_sent = 0;
    int arrows_checked = 0;
    int degenerate_seen = 0;
    bit idle_enabled = 1'b1;

    arrow_head_screen_geometry_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vec_x(vec_x), .vec_y(vec_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .tip_col(tip_col), .tip_row(tip_row),
        .left_col(left_col), .left_row(left_row),
        .right_col(right_col), .right_row(right_row),
        .degenerate(degenerate)
    );

    always #5 clk = ~clk;

    // Integer square root, one result bit per step.
    function automatic logic [63:0] root_of(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 64'd0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Head offset in Q.16, rounded half away from zero.
    function automatic longint head_offset_of(input longint a, input int k,
                                              input logic [63:0] r);
        logic [63:0] m;
        logic [63:0] num;
        logic [63:0] q;
        m = (a < 0) ? 64'(-a) : 64'(a);
        num = (m << k) * HeadHalfWidth;
        q = (2 * num + r) / (2 * r);
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Round a Q.16 screen coordinate to a pixel and saturate.
    function automatic logic signed [15:0] pixel_of(input longint v);
        longint q;
        q = (v + 32768) >>> 16;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic logic signed [15:0] col_of(input longint p);
        return pixel_of(longint'(sh_hc) * 65536 + p * longint'(sh_hs));
    endfunction

    function automatic logic signed [15:0] row_of(input longint p);
        return pixel_of(longint'(sh_vc) * 65536 - p * longint'(sh_vs));
    endfunction

    // Expected arrow for one vector under the current mapping.
    function automatic arrow_pixels_t arrow_of(input logic signed [15:0] x,
                                               input logic signed [15:0] y);
        arrow_pixels_t e;
        longint sx, sy, px, py, lx, ly, rx, ry, off_a, off_b;
        logic [63:0] len2, r;
        int k;
        sx = x;
        sy = y;
        px = sx * (1 << ahsg_pkg::PosShift);
        py = sy * (1 << ahsg_pkg::PosShift);
        lx = px; ly = py; rx = px; ry = py;
        len2 = 64'(sx * sx + sy * sy);
        if (len2 != 0)
        begin
            k = 0;
            while (len2 < (64'd1 << 60))
            begin
                len2 = len2 << 2;
                k++;
            end
            r = root_of(len2);
            off_a = head_offset_of(sx - sy, k, r);
            off_b = head_offset_of(sx + sy, k, r);
            lx = px - off_a;
            ly = py - off_b;
            rx = px - off_b;
            ry = py + off_a;
        end
        e.tip_col = col_of(px);
        e.tip_row = row_of(py);
        e.left_col = col_of(lx);
        e.left_row = row_of(ly);
        e.right_col = col_of(rx);
        e.right_row = row_of(ry);
        e.degenerate = (len2 == 0);
        return e;
    endfunction

    // Record the expected arrow for every accepted vector transaction.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            pending_arrows.push_back(arrow_of(vec_x, vec_y));
            vectors_sent++;
        end
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        arrow_pixels_t e;
        if (rst_n && done)
        begin
            if (pending_arrows.size() == 0)
            begin
                $error("result with no vector outstanding");
                errors++;
            end
            else
            begin
                e = pending_arrows.pop_front();
                arrows_checked++;
                if (degenerate)
                    degenerate_seen++;
                if (tip_col !== e.tip_col)
                begin
                    $error("tip_col: expected %0d, got %0d", e.tip_col, tip_col);
                    errors++;
                end
                if (tip_row !== e.tip_row)
                begin
                    $error("tip_row: expected %0d, got %0d", e.tip_row, tip_row);
                    errors++;
                end
                if (left_col !== e.left_col)
                begin
                    $error("left_col: expected %0d, got %0d", e.left_col, left_col);
                    errors++;
                end
                if (left_row !== e.left_row)
                begin
                    $error("left_row: expected %0d, got %0d", e.left_row, left_row);
                    errors++;
                end
                if (right_col !== e.right_col)
                begin
                    $error("right_col: expected %0d, got %0d", e.right_col, right_col);
                    errors++;
                end
                if (right_row !== e.right_row)
                begin
                    $error("right_row: expected %0d, got %0d", e.right_row, right_row);
                    errors++;
                end
                if (degenerate !== e.degenerate)
                begin
                    $error("degenerate: expected %0d, got %0d", e.degenerate, degenerate);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Send one vector transaction, with an occasional burst of idle cycles first.
    task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        start <= 1'b1;
        vec_x <= x;
        vec_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Let every outstanding arrow come back, then let the pipeline settle.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_arrows.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // One register write; the caller drops cfg_valid after the last one.
    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            IdxW'(ahsg_pkg::RegHorizCenter): sh_hc = data[11:0];
            IdxW'(ahsg_pkg::RegVertCenter):  sh_vc = data[11:0];
            IdxW'(ahsg_pkg::RegHorizScale):  sh_hs = data[9:0];
            IdxW'(ahsg_pkg::RegVertScale):   sh_vs = data[9:0];
            default: ;
        endcase
    endtask

    task automatic set_mapping(input logic [31:0] hc, input logic [31:0] vc,
                               input logic [31:0] hs, input logic [31:0] vs);
        drain();
        write_reg(IdxW'(ahsg_pkg::RegHorizCenter), hc);
        write_reg(IdxW'(ahsg_pkg::RegVertCenter), vc);
        write_reg(IdxW'(ahsg_pkg::RegHorizScale), hs);
        write_reg(IdxW'(ahsg_pkg::RegVertScale), vs);
        cfg_valid <= 1'b0;
    endtask

    // Extremes of both components, axis directions and the zero vector.
    task automatic test_directed;
        send_vector(16'sd0, 16'sd0);
        send_vector(16'sh7fff, 16'sh7fff);
        send_vector(-16'sh8000, -16'sh8000);
        send_vector(16'sh7fff, -16'sh8000);
        send_vector(-16'sh8000, 16'sh7fff);
        send_vector(16'sd1, 16'sd0);
        send_vector(16'sd0, 16'sd1);
        send_vector(-16'sd1, 16'sd0);
        send_vector(16'sd0, -16'sd1);
        send_vector(16'sd256, 16'sd0);
        send_vector(16'sd0, -16'sd256);
        send_vector(16'sd1, 16'sd1);
        send_vector(-16'sd1, -16'sd1);
        send_vector(16'sh5555, -16'sh5556);
        send_vector(16'sd128, -16'sd128);
        send_vector(16'sh7fff, 16'sd0);
        send_vector(-16'sh8000, 16'sd0);
        send_vector(16'sd0, 16'sh7fff);
        send_vector(16'sd3, 16'sd4);
    endtask

    // A zero scale puts every point on the centre; the zero vector is degenerate.
    task automatic test_zero_scale;
        set_mapping(32'd2047, 32'd1000, 32'd0, 32'd0);
        send_vector(16'sh7fff, -16'sh8000);
        send_vector(16'sd0, 16'sd0);
        send_vector(-16'sd37, 16'sd1234);
        send_vector(16'sd1, 16'sd0);
    endtask

    // Unused register indexes are ignored; excess data bits are dropped.
    task automatic test_register_masking;
        drain();
        write_reg(RegFirstUnused, 32'hffff_ffff);
        write_reg(IdxW'($urandom_range(5, 255)), $urandom);
        write_reg(IdxW'(ahsg_pkg::RegHorizCenter), 32'hffff_f123);
        write_reg(IdxW'(ahsg_pkg::RegVertCenter), 32'h8000_0fff);
        write_reg(IdxW'(ahsg_pkg::RegHorizScale), 32'hffff_fc05);
        write_reg(IdxW'(ahsg_pkg::RegVertScale), 32'h0000_ffff);
        cfg_valid <= 1'b0;
        send_vector(16'sh7fff, 16'sh7fff);
        send_vector(-16'sh8000, 16'sd5);
        send_vector(16'sd0, 16'sd0);
    endtask

    // Random vectors: full range, short vectors that stay on screen, axes and tiny ones.
    task automatic test_random_vectors(input int count);
        logic signed [15:0] x, y;
        int kind;
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                x = $urandom;
                y = $urandom;
            end
            else if (kind < 8)
            begin
                x = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
                y = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            end
            else if (kind == 8)
            begin
                x = ($urandom_range(0, 1) != 0) ? 16'sd0 : 16'($urandom);
                y = (x == 0) ? 16'($urandom) : 16'sd0;
            end
            else
            begin
                x = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom_range(0, 3)) - 16'sd1;
                y = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'($urandom_range(0, 3)) - 16'sd1;
            end
            send_vector(x, y);
        end
    endtask

    // Random phases across several mappings, extremes included.
    task automatic test_mapping_sweep;
        set_mapping(32'd4095, 32'd4095, 32'd1023, 32'd1023);
        test_random_vectors(230);
        set_mapping(32'd0, 32'd0, 32'd1023, 32'd1023);
        test_random_vectors(230);
        set_mapping(32'd640, 32'd480, 32'd1, 32'd1);
        test_random_vectors(230);
        set_mapping($urandom, $urandom, $urandom, $urandom);
        test_random_vectors(230);
        set_mapping($urandom, $urandom, 32'($urandom_range(0, 8)), 32'($urandom_range(0, 8)));
        test_random_vectors(230);
        // Back to back with no idle cycles at all.
        idle_enabled = 1'b0;
        set_mapping(32'd2048, 32'd2048, $urandom, $urandom);
        test_random_vectors(300);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_mapping(32'd100, 32'd200, 32'd300, 32'd40);
        test_directed();
        test_zero_scale();
        test_register_masking();
        test_mapping_sweep();
        drain();

        if (pending_arrows.size() != 0)
        begin
            $error("%0d arrows never came back", pending_arrows.size());
            errors++;
        end
        $display("Covered %0d vectors over several screen mappings, extremes included;",
                 vectors_sent);
        $display("%0d arrows compared, %0d of them degenerate.", arrows_checked,
                 degenerate_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
